FILE: rtl/core/ewtt_pkg.sv
// Shared types and constants for the encoder wheel threshold tracker.
// Used by ewtt_track, ewtt_scale and encoder_wheel_threshold_tracker_unit.
package ewtt_pkg;

	localparam int PosW      = 24;   // position counter width
	localparam int ThrW      = 16;   // threshold register width
	localparam int CntW      = 24;   // relative_counts port width
	localparam int DispW     = 30;   // displacement_centideg port width
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;

	localparam int ScaleK    = 4500;
	localparam int ScaleW    = 13;
	localparam int RoundK    = 64;
	localparam int ShiftK    = 7;
	localparam int ProdW     = PosW + ScaleW;
	localparam int ScW       = ProdW - ShiftK;
	localparam int DispWideW = (ScW > DispW) ? ScW : DispW;
	localparam int CntWideW  = (PosW > CntW) ? PosW : CntW;

	// request opcodes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_REARM  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// side / direction codes
	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_RIGHT = 2'd1;
	localparam logic [1:0] SIDE_LEFT  = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_EASY    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_NORMAL  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_REVERSE = 2'd2;

	typedef struct packed {
		logic [ThrW-1:0] easy;
		logic [ThrW-1:0] normal;
		logic            reverse;
	} ewtt_cfg_t;

	typedef struct packed {
		logic [PosW-1:0] counts;
		logic            reached;
		logic            missed;
	} ewtt_item_t;

endpackage

FILE: rtl/core/ewtt_track.sv
// Trial state of the tracker: position counter, trial start, flags.
// Applies one request per accepted cycle and registers counts and flags.
// Depends on ewtt_pkg.
module ewtt_track (
	input  logic               clk,
	input  logic               arst_n,
	input  ewtt_pkg::ewtt_cfg_t cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic               pin_a,
	input  logic               pin_b,
	input  logic               easy_select,
	input  logic [1:0]         side,
	output logic               s1_valid,
	input  logic               s1_ready,
	output ewtt_pkg::ewtt_item_t item_s1
);
	import ewtt_pkg::*;

	logic [PosW-1:0]        pos_q, start_q, pos_nx, start_nx, diff;
	logic                   prev_a_q, prev_a_nx;
	logic [1:0]             dir_q, dir_nx;
	logic [ThrW-1:0]        thr_q, thr_nx;
	logic                   reached_q, missed_q, reached_nx, missed_nx;
	logic                   rep_reached, rep_missed;
	logic signed [PosW:0]   cnt_x, thr_x;
	logic                   ge, le;
	logic                   valid_s1;
	logic                   accept;

	assign in_ready = !valid_s1 || s1_ready;
	assign accept   = in_valid && in_ready;
	assign s1_valid = valid_s1;

	always_comb begin
		pos_nx    = pos_q;
		start_nx  = start_q;
		prev_a_nx = prev_a_q;
		dir_nx    = dir_q;
		thr_nx    = thr_q;
		reached_nx = reached_q;
		missed_nx  = missed_q;
		rep_reached = reached_q;
		rep_missed  = (dir_q != SIDE_NONE) && missed_q;

		if (op == OP_SAMPLE) begin
			if (pin_a && !prev_a_q)
				pos_nx = pin_b ? pos_q - PosW'(1) : pos_q + PosW'(1);
			prev_a_nx = pin_a;
		end
		if (op == OP_REARM)
			start_nx = pos_q;

		diff  = pos_nx - start_nx;
		cnt_x = (PosW+1)'(signed'(diff));
		thr_x = signed'({{(PosW+1-ThrW){1'b0}}, thr_q});
		ge    = cnt_x >= thr_x;
		le    = cnt_x <= -thr_x;

		case (op)
			OP_SAMPLE: begin
				case (dir_q)
					SIDE_RIGHT: begin
						if (ge) reached_nx = 1'b1;
						if (le) missed_nx  = 1'b1;
					end
					SIDE_LEFT: begin
						if (le) reached_nx = 1'b1;
						if (ge) missed_nx  = 1'b1;
					end
					default: begin
						if (ge || le) reached_nx = 1'b1;
					end
				endcase
				rep_reached = reached_nx;
				rep_missed  = (dir_q != SIDE_NONE) && missed_nx;
			end
			OP_REARM: begin
				// side code three counts as no side; reverse swaps left and right
				case (side)
					SIDE_RIGHT: dir_nx = cfg.reverse ? SIDE_LEFT : SIDE_RIGHT;
					SIDE_LEFT:  dir_nx = cfg.reverse ? SIDE_RIGHT : SIDE_LEFT;
					default:    dir_nx = SIDE_NONE;
				endcase
				thr_nx      = easy_select ? cfg.easy : cfg.normal;
				reached_nx  = 1'b0;
				missed_nx   = 1'b0;
				rep_reached = 1'b0;
				rep_missed  = 1'b0;
			end
			OP_READ: begin
				reached_nx = 1'b0;
				missed_nx  = 1'b0;
			end
			default: begin
				// unused opcode: report only
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			prev_a_q  <= 1'b0;
			dir_q     <= SIDE_NONE;
			thr_q     <= '0;
			reached_q <= 1'b0;
			missed_q  <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				pos_q     <= pos_nx;
				start_q   <= start_nx;
				prev_a_q  <= prev_a_nx;
				dir_q     <= dir_nx;
				thr_q     <= thr_nx;
				reached_q <= reached_nx;
				missed_q  <= missed_nx;
			end
			if (in_ready)
				valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.counts  <= diff;
			item_s1.reached <= rep_reached;
			item_s1.missed  <= rep_missed;
		end
	end

	a_rearm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_REARM |=> !reached_q && !missed_q && !item_s1.reached
			&& !item_s1.missed && item_s1.counts == '0)
		else $error("rearm did not clear flags and counts");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_READ |=> !reached_q && !missed_q)
		else $error("read did not clear held flags");

	a_no_side_no_miss: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op != OP_REARM && dir_q == SIDE_NONE |=> !item_s1.missed)
		else $error("missed reported with no side set");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_ready |=> valid_s1 && $stable(item_s1))
		else $error("stage one lost or changed a pending request");

endmodule

FILE: rtl/core/ewtt_scale.sv
// Output stage: converts relative counts to centidegrees and holds the result.
// One constant multiply, rounding shift and sign restore. Depends on ewtt_pkg.
module ewtt_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       reverse,
	input  logic                       s1_valid,
	output logic                       s1_ready,
	input  ewtt_pkg::ewtt_item_t       item_s1,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ewtt_pkg::CntW-1:0]  relative_counts,
	output logic [ewtt_pkg::DispW-1:0] displacement_centideg,
	output logic                       reached,
	output logic                       missed
);
	import ewtt_pkg::*;

	logic                       valid_q;
	logic                       neg, flip;
	logic [PosW-1:0]            mag;
	logic [ProdW-1:0]           prod;
	logic [DispWideW-1:0]       sc_w, disp_w;
	logic signed [CntWideW-1:0] cnt_w;
	logic                       load;

	assign s1_ready  = !valid_q || out_ready;
	assign load      = s1_valid && s1_ready;
	assign out_valid = valid_q;

	always_comb begin
		neg    = item_s1.counts[PosW-1];
		mag    = neg ? -item_s1.counts : item_s1.counts;
		prod   = ProdW'(mag) * ProdW'(ScaleK) + ProdW'(RoundK);
		sc_w   = DispWideW'(prod[ProdW-1:ShiftK]);
		flip   = neg ^ reverse;
		disp_w = flip ? -sc_w : sc_w;
		cnt_w  = CntWideW'(signed'(item_s1.counts));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (s1_ready)
			valid_q <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			relative_counts       <= cnt_w[CntW-1:0];
			displacement_centideg <= disp_w[DispW-1:0];
			reached               <= item_s1.reached;
			missed                <= item_s1.missed;
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

	a_zero_disp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && relative_counts == '0 |-> displacement_centideg == '0)
		else $error("nonzero displacement for zero counts");

	a_sign_match: assert property (@(posedge clk) disable iff (!arst_n)
		load && !reverse && !item_s1.counts[PosW-1] |=> !displacement_centideg[DispW-1])
		else $error("displacement sign disagrees with counts");

endmodule

FILE: rtl/core/encoder_wheel_threshold_tracker_unit.sv
// Encoder wheel threshold tracker, top level.
// Instantiates ewtt_track and ewtt_scale; depends on ewtt_pkg.
//
// Requests enter on the in_valid/in_ready channel: op selects a pin sample,
// a rearm of the trial or a read-and-clear of the reached/missed flags.
// Every request yields exactly one result on out_valid/out_ready carrying
// relative_counts, displacement_centideg and the reported flags.
// A request goes from acceptance through the stage and output registers to
// out_valid. Throughput is one request per cycle while out_ready is high:
// trial state updates in the accept cycle, the stage register feeds the output
// stage, whose constant multiply by 4500 sits between those two registers.
// When the receiver holds out_ready low the result register holds, the
// stage register fills, and then in_ready drops; it rises again in the
// cycle the receiver takes a result.
// The user must write the threshold and reverse registers through cfg_we/cfg_index/
// cfg_data only while no request is in flight, which the block does not enforce; unused indexes are ignored.
// Reset clears position, trial start, direction, threshold, flags, the
// registers and both valid stages; the block takes requests right away.
module encoder_wheel_threshold_tracker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ewtt_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ewtt_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic                          pin_a,
	input  logic                          pin_b,
	input  logic                          easy_select,
	input  logic [1:0]                    side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ewtt_pkg::CntW-1:0]     relative_counts,
	output logic [ewtt_pkg::DispW-1:0]    displacement_centideg,
	output logic                          reached,
	output logic                          missed
);
	import ewtt_pkg::*;

	ewtt_cfg_t  cfg_q;
	ewtt_item_t item_s1;
	logic       s1_valid, s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EASY:    cfg_q.easy    <= cfg_data[ThrW-1:0];
				CFG_NORMAL:  cfg_q.normal  <= cfg_data[ThrW-1:0];
				CFG_REVERSE: cfg_q.reverse <= cfg_data[0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	ewtt_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.pin_a       (pin_a),
		.pin_b       (pin_b),
		.easy_select (easy_select),
		.side        (side),
		.s1_valid    (s1_valid),
		.s1_ready    (s1_ready),
		.item_s1     (item_s1)
	);

	ewtt_scale u_scale (
		.clk                   (clk),
		.arst_n                (arst_n),
		.reverse               (cfg_q.reverse),
		.s1_valid              (s1_valid),
		.s1_ready              (s1_ready),
		.item_s1               (item_s1),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.relative_counts       (relative_counts),
		.displacement_centideg (displacement_centideg),
		.reached               (reached),
		.missed                (missed)
	);

endmodule

FILE: dv/encoder_wheel_threshold_tracker_unit_tb.sv
// Self-checking testbench for encoder_wheel_threshold_tracker_unit.
// Predicts every result from its own copy of the trial state and checks each
// result in order; depends on ewtt_pkg and the unit's RTL only.
module encoder_wheel_threshold_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ewtt_pkg::*;

	localparam logic [1:0]         OP_IGNORED  = 2'd3;
	localparam logic [1:0]         SIDE_UNUSED = 2'd3;
	localparam logic [CfgIdxW-1:0] CFG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [CntW-1:0]  counts;
		logic [DispW-1:0] disp;
		logic             reached;
		logic             missed;
	} tracker_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          op;
	logic                pin_a;
	logic                pin_b;
	logic                easy_select;
	logic [1:0]          side;
	logic                out_valid;
	logic                out_ready;
	logic [CntW-1:0]     relative_counts;
	logic [DispW-1:0]    displacement_centideg;
	logic                reached;
	logic                missed;

	// predictor copy of the trial state and registers
	logic [PosW-1:0] wheel_pos;
	logic [PosW-1:0] trial_start;
	logic            last_a;
	logic [1:0]      trial_dir;
	logic [ThrW-1:0] trial_thr;
	logic            reached_flag;
	logic            missed_flag;
	logic [ThrW-1:0] cfg_easy;
	logic [ThrW-1:0] cfg_normal;
	logic            cfg_reverse;

	tracker_result_t pending_results[$];
	tracker_result_t want;
	tracker_result_t got;
	int              mismatch_count;
	int              requests_sent;
	int              hold_req;
	int              stall_left;
	bit              gaps_on;
	bit              stall_on;
	logic            walk_a;

	encoder_wheel_threshold_tracker_unit DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.op                   (op),
		.pin_a                (pin_a),
		.pin_b                (pin_b),
		.easy_select          (easy_select),
		.side                 (side),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.relative_counts      (relative_counts),
		.displacement_centideg(displacement_centideg),
		.reached              (reached),
		.missed               (missed)
	);

	always #10 clk = ~clk;

	function automatic longint counts_since_start();
		logic [PosW-1:0] diff;
		longint          c;
		diff = wheel_pos - trial_start;
		c = $signed(diff);
		return c;
	endfunction

	function automatic logic [DispW-1:0] centideg_of(input longint c);
		longint mag;
		longint v;
		mag = (c < 0) ? -c : c;
		v = (mag * ScaleK + RoundK) >> ShiftK;
		if (c < 0) v = -v;
		if (cfg_reverse) v = -v;
		return v[DispW-1:0];
	endfunction

	task automatic track_request(input logic [1:0] r_op, input logic r_a, input logic r_b,
			input logic r_easy, input logic [1:0] r_side);
		longint          counts;
		longint          thr;
		longint          proj;
		logic            rep_reached;
		logic            rep_missed;
		logic [1:0]      d;
		tracker_result_t res;
		case (r_op)
			OP_SAMPLE: begin
				if (r_a && !last_a) wheel_pos = r_b ? wheel_pos - 1'b1 : wheel_pos + 1'b1;
				last_a = r_a;
				counts = counts_since_start();
				thr = longint'(trial_thr);
				if (trial_dir == SIDE_NONE) begin
					if (counts >= thr || counts <= -thr) reached_flag = 1'b1;
				end else begin
					proj = (trial_dir == SIDE_RIGHT) ? counts : -counts;
					if (proj >= thr) reached_flag = 1'b1;
					if (proj <= -thr) missed_flag = 1'b1;
				end
				rep_reached = reached_flag;
				rep_missed = (trial_dir != SIDE_NONE) && missed_flag;
			end
			OP_REARM: begin
				d = (r_side == SIDE_RIGHT) ? SIDE_RIGHT :
					(r_side == SIDE_LEFT) ? SIDE_LEFT : SIDE_NONE;
				if (cfg_reverse && d != SIDE_NONE)
					d = (d == SIDE_RIGHT) ? SIDE_LEFT : SIDE_RIGHT;
				trial_dir = d;
				trial_thr = r_easy ? cfg_easy : cfg_normal;
				trial_start = wheel_pos;
				reached_flag = 1'b0;
				missed_flag = 1'b0;
				counts = counts_since_start();
				rep_reached = 1'b0;
				rep_missed = 1'b0;
			end
			OP_READ: begin
				counts = counts_since_start();
				rep_reached = reached_flag;
				rep_missed = (trial_dir != SIDE_NONE) && missed_flag;
				reached_flag = 1'b0;
				missed_flag = 1'b0;
			end
			default: begin
				counts = counts_since_start();
				rep_reached = reached_flag;
				rep_missed = (trial_dir != SIDE_NONE) && missed_flag;
			end
		endcase
		res.counts = counts[CntW-1:0];
		res.disp = centideg_of(counts);
		res.reached = rep_reached;
		res.missed = rep_missed;
		pending_results.push_back(res);
	endtask

	task automatic send_request(input logic [1:0] r_op, input logic r_a, input logic r_b,
			input logic r_easy, input logic [1:0] r_side);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= r_op;
		pin_a <= r_a;
		pin_b <= r_b;
		easy_select <= r_easy;
		side <= r_side;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_request(r_op, r_a, r_b, r_easy, r_side);
		if (r_op != OP_IGNORED) requests_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_config(input logic [ThrW-1:0] e, input logic [ThrW-1:0] n,
			input logic [CfgDataW-1:0] r);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_EASY;
		cfg_data <= e;
		@(posedge clk);
		cfg_index <= CFG_NORMAL;
		cfg_data <= n;
		@(posedge clk);
		cfg_index <= CFG_REVERSE;
		cfg_data <= r;
		@(posedge clk);
		// unused index must leave every register alone
		cfg_index <= CFG_UNUSED;
		cfg_data <= CfgDataW'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_easy = e;
		cfg_normal = n;
		cfg_reverse = r[0];
	endtask

	// rearm, walk the wheel mostly one way with some noise, then read the flags
	task automatic run_trial();
		int         steps;
		logic       dir_b;
		logic [1:0] pick;
		pick = ($urandom_range(0, 9) == 0) ? SIDE_UNUSED : 2'($urandom_range(0, 2));
		send_request(OP_REARM, 1'($urandom), 1'($urandom), 1'($urandom), pick);
		steps = $urandom_range(4, 60);
		dir_b = 1'($urandom);
		repeat (steps) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
					2'($urandom));
			end else begin
				walk_a = ~walk_a;
				send_request(OP_SAMPLE, walk_a,
					($urandom_range(0, 9) == 0) ? ~dir_b : dir_b,
					1'($urandom), 2'($urandom));
			end
		end
		send_request(OP_READ, 1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
	endtask

	task automatic test_directed_basics();
		set_config(16'h0000, 16'hFFFF, 16'h0000);
		send_request(OP_READ, 1'b1, 1'b1, 1'b1, SIDE_LEFT);
		// zero threshold with no side: reached at once
		send_request(OP_SAMPLE, 1'b0, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_IGNORED, 1'b1, 1'b0, 1'b1, SIDE_UNUSED);
		send_request(OP_READ, 1'b0, 1'b0, 1'b0, SIDE_NONE);
		// zero threshold with a side: both flags on the first sample
		send_request(OP_REARM, 1'b0, 1'b0, 1'b1, SIDE_RIGHT);
		send_request(OP_SAMPLE, 1'b0, 1'b0, 1'b1, SIDE_UNUSED);
		send_request(OP_SAMPLE, 1'b1, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_READ, 1'b1, 1'b1, 1'b0, SIDE_RIGHT);
		send_request(OP_READ, 1'b0, 1'b1, 1'b1, SIDE_LEFT);
		// largest threshold, step down toward a left side
		send_request(OP_REARM, 1'b1, 1'b1, 1'b0, SIDE_LEFT);
		send_request(OP_SAMPLE, 1'b0, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b1, 1'b1, 1'b1, SIDE_RIGHT);
		send_request(OP_SAMPLE, 1'b1, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_READ, 1'b0, 1'b0, 1'b1, SIDE_NONE);
		// side code three behaves as no side
		send_request(OP_REARM, 1'b0, 1'b0, 1'b0, SIDE_UNUSED);
		send_request(OP_SAMPLE, 1'b0, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b1, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_READ, 1'b1, 1'b0, 1'b0, SIDE_RIGHT);
	endtask

	task automatic test_reverse_direction();
		set_config(16'd2, 16'd1, {15'($urandom), 1'b1});
		// right flips to left, so moving down counts toward the target
		send_request(OP_REARM, 1'b0, 1'b0, 1'b1, SIDE_RIGHT);
		send_request(OP_SAMPLE, 1'b0, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b1, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b0, 1'b1, 1'b1, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b1, 1'b1, 1'b1, SIDE_NONE);
		send_request(OP_READ, 1'b0, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_REARM, 1'b1, 1'b1, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b0, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_SAMPLE, 1'b1, 1'b0, 1'b0, SIDE_NONE);
		send_request(OP_READ, 1'b0, 1'b0, 1'b0, SIDE_NONE);
	endtask

	task automatic test_random_trials(input int n_items, input logic [ThrW-1:0] e,
			input logic [ThrW-1:0] n, input logic rev);
		int stop_at;
		set_config(e, n, {15'($urandom), rev});
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) run_trial();
	endtask

	task automatic test_input_stall();
		bit keep_gaps;
		keep_gaps = gaps_on;
		gaps_on = 1'b0;
		send_request(OP_REARM, 1'b0, 1'b0, 1'($urandom), SIDE_RIGHT);
		// hold the receiver off while requests keep coming
		hold_req = 60;
		repeat (18) begin
			walk_a = ~walk_a;
			send_request(OP_SAMPLE, walk_a, 1'b0, 1'($urandom), 2'($urandom));
		end
		send_request(OP_READ, 1'b0, 1'b0, 1'b0, SIDE_NONE);
		gaps_on = keep_gaps;
	endtask

	task automatic test_steady_stream();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		test_random_trials(170, 16'($urandom_range(0, 6)), 16'($urandom_range(3, 20)),
			1'($urandom));
	endtask

	// receiver: random stall bursts plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (stall_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic flag_mismatch(input string what, input tracker_result_t e_r,
			input tracker_result_t a_r);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("%0t %s: expected counts=%0d disp=%0d reached=%b missed=%b,",
				$realtime, what, $signed(e_r.counts), $signed(e_r.disp), e_r.reached,
				e_r.missed);
			$display(" got counts=%0d disp=%0d reached=%b missed=%b",
				$signed(a_r.counts), $signed(a_r.disp), a_r.reached, a_r.missed);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got.counts = relative_counts;
			got.disp = displacement_centideg;
			got.reached = reached;
			got.missed = missed;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (want.counts !== got.counts || want.disp !== got.disp ||
						want.reached !== got.reached || want.missed !== got.missed)
					flag_mismatch("result mismatch", want, got);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_SAMPLE;
		pin_a = 1'b0;
		pin_b = 1'b0;
		easy_select = 1'b0;
		side = SIDE_NONE;
		out_ready = 1'b0;
		wheel_pos = '0;
		trial_start = '0;
		last_a = 1'b0;
		trial_dir = SIDE_NONE;
		trial_thr = '0;
		reached_flag = 1'b0;
		missed_flag = 1'b0;
		cfg_easy = '0;
		cfg_normal = '0;
		cfg_reverse = 1'b0;
		mismatch_count = 0;
		requests_sent = 0;
		hold_req = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		walk_a = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_basics();
		test_reverse_direction();
		test_random_trials(170, 16'($urandom_range(0, 8)), 16'($urandom_range(5, 25)), 1'b0);
		test_random_trials(100, 16'h0000, 16'hFFFF, 1'b1);
		test_random_trials(170, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 30)), 1'b1);
		test_input_stall();
		test_random_trials(100, 16'($urandom), 16'($urandom_range(0, 20)), 1'b0);
		test_steady_stream();

		in_valid <= 1'b0;
		for (int w = 0; w < 2000 && pending_results.size() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			mismatch_count += pending_results.size();
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
